// File: rtl/core/lpcp_pkg.sv
// shared types and constants for the lidar point camera projection unit
// no dependencies

package lpcp_pkg;

	typedef enum logic [1:0] {
		CMD_CLEAR   = 2'd0,
		CMD_APPEND  = 2'd1,
		CMD_PROJECT = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		REG_FOCAL_X  = 3'd0,
		REG_FOCAL_Y  = 3'd1,
		REG_CENTER_X = 3'd2,
		REG_CENTER_Y = 3'd3,
		REG_OFFSET_X = 3'd4,
		REG_OFFSET_Y = 3'd5,
		REG_OFFSET_Z = 3'd6,
		REG_IMAGE    = 3'd7
	} reg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_BOUND,
		ST_SQRT,
		ST_RDREQ,
		ST_RDWAIT,
		ST_TEST,
		ST_OUT
	} state_t;

	// widths of the datapath
	localparam int CamW   = 20;          // camera coordinate, signed
	localparam int NumW   = 37;          // focal * cam, signed
	localparam int QuoW   = 38;          // floor quotient, signed
	localparam int PixW   = 40;          // u or v in 1/16 px, signed
	localparam int SqW    = 36;          // x^2 + y^2 fits in 36 bits
	localparam int RootW  = 18;
	localparam int DivSteps = 37;

	// controller to datapath
	typedef struct packed {
		logic load;       // latch point and form camera coordinates
		logic mul;        // register focal products
		logic div_start;  // load divider and root units
		logic div_step;   // one division and one root step
		logic div_fix;    // floor correction, add centre
		logic bound;      // image bound check
		logic rd_req;     // request table read
		logic test;       // compare against read box
		logic idx_inc;    // advance box index
		logic hit;        // latch match
		logic clr_res;    // clear match result
	} cmd_bus_t;

	// datapath to controller
	typedef struct packed {
		logic front;      // cam_z > 0
		logic inview;
		logic step_done;
		logic box_hit;
		logic idx_last;   // index at the last stored box
		logic table_empty;
	} sts_bus_t;

endpackage

// File: rtl/core/lidar_point_camera_projection_unit.sv
// top level of the lidar point camera projection unit: stream ports, apb
// registers, controller and datapath; uses lpcp_pkg, lpcp_ctrl, lpcp_dpath
//
// channel   | direction | contents
// s_axis    | in        | one request: box edit or point to project
// m_axis    | out       | one result per project request
// apb       | in        | eight configuration registers at 4*i
//
// a project request offers its result after one multiply state, the division
// state (operand load plus 37 quotient bits, the 18 root steps run alongside),
// a state that adds the principal point, one bound check, then read, wait and
// test per box, for each of the k boxes examined (0 to MAX_BOXES). a point
// behind the camera is offered after the multiply state. clear and append are
// taken while idle. arst_n clears the fsm, registers and box count; table
// contents are left as they were. the result holds on m_axis until taken;
// s_axis is ready again the cycle after; not ready while busy.

module lidar_point_camera_projection_unit import lpcp_pkg::*; #(
	parameter int MAX_BOXES = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: cmd[1:0], point_x[19:2], point_y[37:20], point_z[55:38],
	// box_center_x[71:56], box_center_y[87:72], box_width[103:88],
	// box_height[119:104]
	input  logic [119:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: in_view[0], pixel_u[12:1], pixel_v[24:13], matched[25],
	// box_index[29:26], distance_mm[47:30]
	output logic [47:0]  m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [4:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int IdxW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
	localparam int CntW = $clog2(MAX_BOXES + 1);

	logic [15:0] focal_x_q, focal_y_q, principal_x_q, principal_y_q;
	logic [15:0] offset_x_q, offset_y_q, offset_z_q;
	logic [23:0] image_size_q;

	assign pready = 1'b1;

	// register writes
	logic wr_en;
	reg_t wr_idx;
	assign wr_en = psel & penable & pwrite;
	assign wr_idx = reg_t'(paddr[4:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q <= 16'd5370;
			focal_y_q <= 16'd5370;
			principal_x_q <= 16'd6400;
			principal_y_q <= 16'd4800;
			offset_x_q <= 16'd700;
			offset_y_q <= 16'd0;
			offset_z_q <= 16'hFD76;
			image_size_q <= 24'd2458400;
		end else if (wr_en) begin
			case (wr_idx)
				REG_FOCAL_X:  focal_x_q <= pwdata[15:0];
				REG_FOCAL_Y:  focal_y_q <= pwdata[15:0];
				REG_CENTER_X: principal_x_q <= pwdata[15:0];
				REG_CENTER_Y: principal_y_q <= pwdata[15:0];
				REG_OFFSET_X: offset_x_q <= pwdata[15:0];
				REG_OFFSET_Y: offset_y_q <= pwdata[15:0];
				REG_OFFSET_Z: offset_z_q <= pwdata[15:0];
				REG_IMAGE:    image_size_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_t'(paddr[4:2]))
			REG_FOCAL_X:  prdata = {16'b0, focal_x_q};
			REG_FOCAL_Y:  prdata = {16'b0, focal_y_q};
			REG_CENTER_X: prdata = {16'b0, principal_x_q};
			REG_CENTER_Y: prdata = {16'b0, principal_y_q};
			REG_OFFSET_X: prdata = {{16{offset_x_q[15]}}, offset_x_q};
			REG_OFFSET_Y: prdata = {{16{offset_y_q[15]}}, offset_y_q};
			REG_OFFSET_Z: prdata = {{16{offset_z_q[15]}}, offset_z_q};
			REG_IMAGE:    prdata = {8'b0, image_size_q};
			default:      prdata = '0;
		endcase
	end

	// request decode
	logic busy, s_take, start;
	cmd_t in_cmd;
	assign s_axis_tready = !busy;
	assign s_take = s_axis_tvalid & s_axis_tready;
	assign in_cmd = cmd_t'(s_axis_tdata[1:0]);
	assign start = s_take && (in_cmd == CMD_PROJECT);

	cmd_bus_t cmd;
	sts_bus_t sts;

	lpcp_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.out_taken(m_axis_tready),
		.sts(sts),
		.cmd(cmd),
		.busy(busy),
		.out_valid(m_axis_tvalid)
	);

	logic in_view, matched;
	logic [11:0] pixel_u, pixel_v;
	logic [3:0] box_index;
	logic [17:0] distance_mm;

	lpcp_dpath #(.MaxBoxes(MAX_BOXES), .IdxW(IdxW), .CntW(CntW)) u_dpath (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.box_wr(s_take && (in_cmd == CMD_APPEND)),
		.box_clr(s_take && (in_cmd == CMD_CLEAR)),
		.box_data(s_axis_tdata[119:56]),
		.point_x(s_axis_tdata[19:2]),
		.point_y(s_axis_tdata[37:20]),
		.point_z(s_axis_tdata[55:38]),
		.focal_x(focal_x_q),
		.focal_y(focal_y_q),
		.principal_x(principal_x_q),
		.principal_y(principal_y_q),
		.offset_x(offset_x_q),
		.offset_y(offset_y_q),
		.offset_z(offset_z_q),
		.image_size(image_size_q),
		.in_view(in_view),
		.pixel_u(pixel_u),
		.pixel_v(pixel_v),
		.matched(matched),
		.box_index(box_index),
		.distance_mm(distance_mm)
	);

	assign m_axis_tdata = {distance_mm, box_index, matched, pixel_v, pixel_u, in_view};

`ifndef SYNTHESIS
	// no new request while a result is pending
	a_no_accept_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("accept during output");
	// a match only for an in-view point
	a_match_in_view: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[25] |-> m_axis_tdata[0]) else $error("match off view");
	// a project request leads to busy next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !s_axis_tready) else $error("start not busy");
`endif

endmodule

// File: rtl/core/lpcp_ctrl.sv
// controller state machine for the projection unit
// uses lpcp_pkg

module lpcp_ctrl import lpcp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  logic     out_taken,
	input  sts_bus_t sts,
	output cmd_bus_t cmd,
	output logic     busy,
	output logic     out_valid
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (start) state_d = ST_MUL;
			ST_MUL:    state_d = sts.front ? ST_DIV : ST_OUT;
			ST_DIV:    if (sts.step_done) state_d = ST_BOUND;
			ST_BOUND:  state_d = ST_SQRT;
			ST_SQRT:   state_d = (!sts.inview || sts.table_empty) ? ST_OUT : ST_RDREQ;
			ST_RDREQ:  state_d = ST_RDWAIT;
			ST_RDWAIT: state_d = ST_TEST;
			ST_TEST:   state_d = (sts.box_hit || sts.idx_last) ? ST_OUT : ST_RDREQ;
			ST_OUT:    if (out_taken) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		busy = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			ST_IDLE: begin
				busy = 1'b0;
				cmd.load = start;
				cmd.clr_res = start;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				cmd.div_start = 1'b1;
			end
			ST_DIV:    cmd.div_step = 1'b1;
			ST_BOUND:  cmd.div_fix = 1'b1;
			ST_SQRT:   cmd.bound = 1'b1;
			ST_RDREQ:  cmd.rd_req = 1'b1;
			ST_RDWAIT: cmd.test = 1'b1;
			ST_TEST: begin
				cmd.hit = sts.box_hit;
				cmd.idx_inc = 1'b1;
			end
			ST_OUT:    out_valid = 1'b1;
			default:   busy = 1'b0;
		endcase
	end

endmodule

// File: rtl/core/lpcp_dpath.sv
// datapath: camera transform, focal products, two serial dividers, serial
// root, box table memory and box compare; uses lpcp_pkg

module lpcp_dpath import lpcp_pkg::*; #(
	parameter int MaxBoxes = 16,
	parameter int IdxW = 4,
	parameter int CntW = 5
) (
	input  logic             clk,
	input  logic             arst_n,
	input  cmd_bus_t         cmd,
	output sts_bus_t         sts,
	input  logic             box_wr,
	input  logic             box_clr,
	input  logic [63:0]      box_data,
	input  logic signed [17:0] point_x,
	input  logic signed [17:0] point_y,
	input  logic signed [17:0] point_z,
	input  logic [15:0]      focal_x,
	input  logic [15:0]      focal_y,
	input  logic [15:0]      principal_x,
	input  logic [15:0]      principal_y,
	input  logic signed [15:0] offset_x,
	input  logic signed [15:0] offset_y,
	input  logic signed [15:0] offset_z,
	input  logic [23:0]      image_size,
	output logic             in_view,
	output logic [11:0]      pixel_u,
	output logic [11:0]      pixel_v,
	output logic             matched,
	output logic [3:0]       box_index,
	output logic [RootW-1:0] distance_mm
);

	logic signed [CamW-1:0] camx_q, camy_q, camz_q;
	logic signed [NumW-1:0] numx_q, numy_q;
	logic [NumW-1:0] remx_q, remy_q, qx_q, qy_q;
	logic [CamW-1:0] den_q;
	logic negx_q, negy_q;
	logic [5:0] step_q;
	logic signed [PixW-1:0] u_q, v_q;
	logic inview_q;
	logic inview_c;
	logic [SqW-1:0] sq_q, rn_q;
	logic [RootW-1:0] root_q;
	logic [SqW-1:0] rbit_q;
	logic [CntW-1:0] count_q;
	logic [IdxW-1:0] idx_q;
	logic [63:0] box_mem [MaxBoxes];
	logic [63:0] rd_q;
	logic hit_q;
	logic match_q;
	logic [IdxW-1:0] match_idx_q;

	// box table
	always_ff @(posedge clk) begin
		if (box_wr && count_q < CntW'(MaxBoxes)) box_mem[count_q[IdxW-1:0]] <= box_data;
		if (cmd.rd_req) rd_q <= box_mem[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (box_clr) count_q <= '0;
		else if (box_wr && count_q < CntW'(MaxBoxes)) count_q <= count_q + 1'b1;
	end

	// serial divide of |num| by cam_z, one quotient bit per cycle
	logic [NumW:0] trx, try_;
	assign trx  = {remx_q, qx_q[NumW-1]} - {{(NumW-CamW+1){1'b0}}, den_q};
	assign try_ = {remy_q, qy_q[NumW-1]} - {{(NumW-CamW+1){1'b0}}, den_q};

	// serial root, two bits per cycle
	logic [SqW:0] rtry;
	assign rtry = {1'b0, rn_q} - ({1'b0, sq_q} + {1'b0, rbit_q});

	logic signed [NumW:0] qsx, qsy;
	always_comb begin
		qsx = negx_q ? -$signed({1'b0, qx_q}) - ((remx_q != '0) ? 1 : 0)
		             : $signed({1'b0, qx_q});
		qsy = negy_q ? -$signed({1'b0, qy_q}) - ((remy_q != '0) ? 1 : 0)
		             : $signed({1'b0, qy_q});
	end

	logic signed [PixW-1:0] wid16, hgt16;
	assign wid16 = PixW'({image_size[11:0], 4'b0});
	assign hgt16 = PixW'({image_size[23:12], 4'b0});

	// image bound check on the freshly formed u and v
	assign inview_c = !u_q[PixW-1] && (u_q < wid16) && !v_q[PixW-1] && (v_q < hgt16);

	// box compare on doubled coordinates
	logic signed [PixW+1:0] u2, v2, bxl, bxh, byl, byh;
	always_comb begin
		u2  = {u_q, 1'b0};
		v2  = {v_q, 1'b0};
		bxl = $signed({2'b0, rd_q[15:0], 1'b0}) - $signed({3'b0, rd_q[47:32]});
		bxh = $signed({2'b0, rd_q[15:0], 1'b0}) + $signed({3'b0, rd_q[47:32]});
		byl = $signed({2'b0, rd_q[31:16], 1'b0}) - $signed({3'b0, rd_q[63:48]});
		byh = $signed({2'b0, rd_q[31:16], 1'b0}) + $signed({3'b0, rd_q[63:48]});
	end

	logic [NumW-1:0] absx, absy;
	assign absx = numx_q[NumW-1] ? NumW'(-numx_q) : NumW'(numx_q);
	assign absy = numy_q[NumW-1] ? NumW'(-numy_q) : NumW'(numy_q);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			camx_q <= CamW'(offset_x) - CamW'(point_y);
			camy_q <= CamW'(offset_y) - CamW'(point_z);
			camz_q <= CamW'(offset_z) + CamW'(point_x);
			sq_q <= SqW'(point_x * point_x) + SqW'(point_y * point_y);
		end
		if (cmd.mul) begin
			numx_q <= $signed({1'b0, focal_x}) * camx_q;
			numy_q <= $signed({1'b0, focal_y}) * camy_q;
		end
		if (cmd.div_start) begin
			// numerators arrive next cycle, so the first step loads them
			den_q <= camz_q;
			step_q <= '0;
			rn_q <= sq_q;
			sq_q <= '0;
			rbit_q <= SqW'(1) << (SqW - 2);
		end
		if (cmd.div_step) begin
			if (step_q == 6'd0) begin
				negx_q <= numx_q[NumW-1];
				negy_q <= numy_q[NumW-1];
				qx_q <= absx;
				qy_q <= absy;
				remx_q <= '0;
				remy_q <= '0;
			end else begin
				if (!trx[NumW]) begin
					remx_q <= trx[NumW-1:0];
					qx_q <= {qx_q[NumW-2:0], 1'b1};
				end else begin
					remx_q <= {remx_q[NumW-2:0], qx_q[NumW-1]};
					qx_q <= {qx_q[NumW-2:0], 1'b0};
				end
				if (!try_[NumW]) begin
					remy_q <= try_[NumW-1:0];
					qy_q <= {qy_q[NumW-2:0], 1'b1};
				end else begin
					remy_q <= {remy_q[NumW-2:0], qy_q[NumW-1]};
					qy_q <= {qy_q[NumW-2:0], 1'b0};
				end
			end
			if (rbit_q != '0) begin
				if (!rtry[SqW]) begin
					rn_q <= rtry[SqW-1:0];
					sq_q <= (sq_q >> 1) + rbit_q;
				end else begin
					sq_q <= sq_q >> 1;
				end
				rbit_q <= rbit_q >> 2;
			end
			step_q <= step_q + 1'b1;
		end
		if (cmd.div_fix) begin
			u_q <= PixW'(qsx) + PixW'(principal_x);
			v_q <= PixW'(qsy) + PixW'(principal_y);
			root_q <= sq_q[RootW-1:0];
		end
		if (cmd.bound) begin
			inview_q <= inview_c;
			idx_q <= '0;
		end
		if (cmd.test)
			hit_q <= (u2 >= bxl) && (u2 <= bxh) && (v2 >= byl) && (v2 <= byh);
		if (cmd.idx_inc) idx_q <= idx_q + 1'b1;
		if (cmd.load) inview_q <= 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
			match_idx_q <= '0;
		end else if (cmd.clr_res) begin
			match_q <= 1'b0;
		end else if (cmd.hit) begin
			match_q <= 1'b1;
			match_idx_q <= idx_q;
		end
	end

	assign sts.front = (camz_q > 0);
	assign sts.inview = inview_c;
	assign sts.step_done = (step_q == 6'(DivSteps));
	assign sts.box_hit = hit_q;
	assign sts.idx_last = (CntW'(idx_q) + 1'b1 >= count_q);
	assign sts.table_empty = (count_q == '0);

	assign in_view = inview_q;
	assign pixel_u = inview_q ? u_q[15:4] : '0;
	assign pixel_v = inview_q ? v_q[15:4] : '0;
	assign matched = inview_q & match_q;
	assign box_index = (inview_q & match_q) ? 4'(match_idx_q) : '0;
	assign distance_mm = (inview_q & match_q) ? root_q : '0;

endmodule

// File: tb/tb_top.sv
// testbench for lidar_point_camera_projection_unit: streams box edits and points,
// predicts each projection result in a scoreboard class; uses lpcp_pkg
`timescale 1ns / 100ps

import lpcp_pkg::*;

typedef struct {
	bit        in_view;
	bit [11:0] pixel_u;
	bit [11:0] pixel_v;
	bit        matched;
	bit [3:0]  box_index;
	bit [17:0] distance_mm;
} proj_result_t;

class projection_scoreboard;
	longint unsigned focal_x = 5370, focal_y = 5370, principal_x = 6400, principal_y = 4800;
	longint offset_x = 700, offset_y = 0, offset_z = -650;
	longint unsigned image_size = 2458400;
	longint box_cx[16], box_cy[16], box_w[16], box_h[16];
	int box_count = 0;
	proj_result_t pending[$];
	int errors = 0;

	function void set_reg(reg_t idx, bit [31:0] val);
		case (idx)
			REG_FOCAL_X:  focal_x = val[15:0];
			REG_FOCAL_Y:  focal_y = val[15:0];
			REG_CENTER_X: principal_x = val[15:0];
			REG_CENTER_Y: principal_y = val[15:0];
			REG_OFFSET_X: offset_x = $signed(val[15:0]);
			REG_OFFSET_Y: offset_y = $signed(val[15:0]);
			REG_OFFSET_Z: offset_z = $signed(val[15:0]);
			REG_IMAGE:    image_size = val[23:0];
			default: ;
		endcase
	endfunction

	function longint floor_div(longint n, longint d);
		longint q;
		q = n / d;
		if (n % d != 0 && n < 0) q = q - 1;
		return q;
	endfunction

	function longint unsigned int_sqrt(longint unsigned n);
		longint unsigned r, bitv;
		r = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (n >= r + bitv) begin
				n = n - (r + bitv);
				r = (r >> 1) + bitv;
			end else begin
				r = r >> 1;
			end
			bitv = bitv >> 2;
		end
		return r;
	endfunction

	// one accepted request; a project request leaves one expected result
	function void note_request(bit [119:0] d);
		cmd_t c;
		longint px, py, pz, cx, cy, cz, u, v, w16, h16;
		proj_result_t r;
		c = cmd_t'(d[1:0]);
		if (c == CMD_CLEAR) begin
			box_count = 0;
		end else if (c == CMD_APPEND) begin
			if (box_count < 16) begin
				box_cx[box_count] = d[71:56];
				box_cy[box_count] = d[87:72];
				box_w[box_count] = d[103:88];
				box_h[box_count] = d[119:104];
				box_count++;
			end
		end else if (c == CMD_PROJECT) begin
			r = '{default: 0};
			px = $signed(d[19:2]);
			py = $signed(d[37:20]);
			pz = $signed(d[55:38]);
			cx = offset_x - py;
			cy = offset_y - pz;
			cz = offset_z + px;
			if (cz > 0) begin
				u = floor_div(longint'(focal_x) * cx, cz) + longint'(principal_x);
				v = floor_div(longint'(focal_y) * cy, cz) + longint'(principal_y);
				w16 = longint'(image_size & 'hFFF) * 16;
				h16 = longint'((image_size >> 12) & 'hFFF) * 16;
				if (u >= 0 && u < w16 && v >= 0 && v < h16) begin
					r.in_view = 1;
					r.pixel_u = 12'(u >> 4);
					r.pixel_v = 12'(v >> 4);
					// first box in table order wins, bounds inclusive
					for (int i = 0; i < box_count; i++) begin
						if (2*u >= 2*box_cx[i] - box_w[i] && 2*u <= 2*box_cx[i] + box_w[i] &&
						    2*v >= 2*box_cy[i] - box_h[i] && 2*v <= 2*box_cy[i] + box_h[i]) begin
							r.matched = 1;
							r.box_index = 4'(i);
							r.distance_mm = 18'(int_sqrt(px*px + py*py));
							break;
						end
					end
				end
			end
			pending = {pending, r};
		end
	endfunction

	function void check_result(bit [47:0] d);
		proj_result_t e;
		if (pending.size() == 0) begin
			$error("unexpected result %h", d);
			errors++;
			return;
		end
		e = pending.pop_front();
		if (d[0] != e.in_view) begin
			$error("in_view exp %0d got %0d", e.in_view, d[0]); errors++;
		end
		if (d[12:1] != e.pixel_u) begin
			$error("pixel_u exp %0d got %0d", e.pixel_u, d[12:1]); errors++;
		end
		if (d[24:13] != e.pixel_v) begin
			$error("pixel_v exp %0d got %0d", e.pixel_v, d[24:13]); errors++;
		end
		if (d[25] != e.matched) begin
			$error("matched exp %0d got %0d", e.matched, d[25]); errors++;
		end
		if (d[29:26] != e.box_index) begin
			$error("box_index exp %0d got %0d", e.box_index, d[29:26]); errors++;
		end
		if (d[47:30] != e.distance_mm) begin
			$error("distance_mm exp %0d got %0d", e.distance_mm, d[47:30]); errors++;
		end
	endfunction
endclass

module tb_top;
	logic         clk = 0;
	logic         arst_n = 0;
	logic         s_axis_tvalid = 0;
	logic         s_axis_tready;
	logic [119:0] s_axis_tdata = '0;
	logic         m_axis_tvalid;
	logic         m_axis_tready = 0;
	logic [47:0]  m_axis_tdata;
	logic         psel = 0, penable = 0, pwrite = 0;
	logic [4:0]   paddr = '0;
	logic [31:0]  pwdata = '0;
	logic [31:0]  prdata;
	logic         pready;

	projection_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit hold_off = 0;

	lidar_point_camera_projection_unit dut (.*);

	always begin
		#1 clk = 1;
		#1 clk = 0;
	end

	// request and result monitors, sampled on the edge that accepts them
	always @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata);
		if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
	end

	// result receiver: random stalls, or a long hold-off while pressure is on
	always @(posedge clk) begin
		if (!arst_n) m_axis_tready <= 0;
		else if (hold_off) m_axis_tready <= 0;
		else m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic bit [119:0] pack_req(cmd_t c, bit [17:0] x, bit [17:0] y, bit [17:0] z,
			bit [15:0] bx, bit [15:0] by, bit [15:0] bw, bit [15:0] bh);
		return {bh, bw, by, bx, z, y, x, c};
	endfunction

	task automatic send_req(bit [119:0] d);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= d;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic reg_write(reg_t idx, bit [31:0] val);
		psel <= 1; pwrite <= 1; penable <= 0;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		sb.set_reg(idx, val);
		psel <= 0; penable <= 0; pwrite <= 0;
	endtask

	// idle the stream, wait out every result plus the request latency
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// random request; mostly points in front of the camera and boxes inside the image
	task automatic send_random();
		int sel;
		longint x, y, z, img_w, img_h;
		bit [15:0] bx, by;
		sel = $urandom_range(99);
		img_w = (sb.image_size & 'hFFF) * 16;
		img_h = ((sb.image_size >> 12) & 'hFFF) * 16;
		if (img_w > 65535) img_w = 65535;
		if (img_h > 65535) img_h = 65535;
		if (sel < 2) begin
			send_req(pack_req(CMD_CLEAR, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom));
		end else if (sel < 20) begin
			bx = $urandom_range(img_w);
			by = $urandom_range(img_h);
			if ($urandom_range(9) == 0)
				send_req(pack_req(CMD_APPEND, $urandom, $urandom, $urandom,
					$urandom, $urandom, $urandom, $urandom));
			else
				send_req(pack_req(CMD_APPEND, $urandom, $urandom, $urandom,
					bx, by, $urandom_range(12000), $urandom_range(12000)));
		end else if (sel < 23) begin
			send_req(pack_req(CMD_NONE, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom));
		end else if (sel < 38) begin
			send_req(pack_req(CMD_PROJECT, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom));
		end else begin
			// well-formed point with camera depth 300 to 40000 ahead of the camera
			x = longint'($urandom_range(40000, 300)) - sb.offset_z;
			if (x > 131071) x = 131071;
			if (x < -131072) x = -131072;
			y = sb.offset_x - (longint'($urandom_range(40000)) - 20000) * (x > 0 ? x : 1) / 40000;
			z = sb.offset_y - (longint'($urandom_range(30000)) - 15000) * (x > 0 ? x : 1) / 40000;
			if (y > 131071) y = 131071;
			if (y < -131072) y = -131072;
			if (z > 131071) z = 131071;
			if (z < -131072) z = -131072;
			send_req(pack_req(CMD_PROJECT, x, y, z, $urandom, $urandom, $urandom, $urandom));
		end
	endtask

	task automatic write_all(bit [15:0] fx, bit [15:0] fy, bit [15:0] cx, bit [15:0] cy,
			bit [15:0] ox, bit [15:0] oy, bit [15:0] oz, bit [23:0] img);
		reg_write(REG_FOCAL_X, fx);
		reg_write(REG_FOCAL_Y, fy);
		reg_write(REG_CENTER_X, cx);
		reg_write(REG_CENTER_Y, cy);
		reg_write(REG_OFFSET_X, ox);
		reg_write(REG_OFFSET_Y, oy);
		reg_write(REG_OFFSET_Z, oz);
		reg_write(REG_IMAGE, img);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// phase a: sender idles lightly, receiver heavily
		send_idle_pct = 36;
		recv_idle_pct = 78;
		send_req(pack_req(CMD_PROJECT, 10000, 0, 0, 0, 0, 0, 0));       // empty table
		send_req(pack_req(CMD_APPEND, 0, 0, 0, 16'hFFFF, 16'hFFFF, 0, 0));
		send_req(pack_req(CMD_APPEND, 0, 0, 0, 0, 0, 16'hFFFF, 16'hFFFF));
		send_req(pack_req(CMD_APPEND, 0, 0, 0, 6400, 4800, 4000, 4000));
		send_req(pack_req(CMD_PROJECT, 10000, 0, 0, 0, 0, 0, 0));       // in view, matched
		send_req(pack_req(CMD_PROJECT, 650, 0, 0, 0, 0, 0, 0));         // depth exactly zero
		send_req(pack_req(CMD_PROJECT, 18'h20000, 0, 0, 0, 0, 0, 0));   // far behind
		send_req(pack_req(CMD_PROJECT, 18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 0, 0, 0, 0));
		send_req(pack_req(CMD_PROJECT, 18'h1FFFF, 18'h20000, 18'h20000, 0, 0, 0, 0));
		send_req(pack_req(CMD_PROJECT, 2000, 18'h1FFFF, 0, 0, 0, 0, 0)); // left of image
		send_req(pack_req(CMD_PROJECT, 2000, 0, 18'h20000, 0, 0, 0, 0)); // below image
		send_req(pack_req(CMD_PROJECT, 30000, 9000, 5000, 0, 0, 0, 0));  // in view, matched
		send_req(pack_req(CMD_NONE, '1, '1, '1, '1, '1, '1, '1));
		send_req(pack_req(CMD_PROJECT, 10000, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
		send_req(pack_req(CMD_PROJECT, 10000, 0, 0, 0, 0, 0, 0));       // table cleared
		repeat (600) send_random();
		drain();

		// phase b: roles swapped, mid-range settings
		write_all(3000, 7000, 5000, 3000, 16'hFE0C, 200, 100, {12'd500, 12'd700});
		send_idle_pct = 78;
		recv_idle_pct = 36;
		repeat (600) send_random();
		drain();

		// phase c: no idling, extreme settings, long receiver hold-off
		write_all(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h8000, 16'h8000,
			24'hFFFFFF);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		fork
			begin
				hold_off = 1;
				repeat (400) @(posedge clk);
				hold_off = 0;
			end
			repeat (350) send_random();
		join
		drain();

		// zero focal lengths, centre and image
		write_all(0, 0, 0, 0, 16'h8000, 16'h7FFF, 16'h7FFF, 0);
		repeat (100) send_random();
		drain();

		// back to the power-on calibration
		write_all(5370, 5370, 6400, 4800, 700, 0, 16'hFD76, 2458400);
		repeat (250) send_random();
		drain();

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

	initial begin
		#4000000;
		$display("tb: failure");
		$finish;
	end
endmodule
